// ----- sv/four_digit_decimal_ascii_formatter_assert.svh -----
// ----------------------------------------------------------------------------
// Four-digit decimal ASCII formatter: assertion macros
// Concurrent assertion wrappers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FOUR_DIGIT_DECIMAL_ASCII_FORMATTER_ASSERT_SVH
`define FOUR_DIGIT_DECIMAL_ASCII_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define FDAF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fdaf assertion failed");
// Checked at every edge, reset included.
`define FDAF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fdaf assertion failed");
`else
`define FDAF_ASSERT(lbl, clk, rst_n, prop)
`define FDAF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- sv/fdaf_pkg.sv -----
// ----------------------------------------------------------------------------
// fdaf_pkg
// Item types, constants and digit helpers of the decimal ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package fdaf_pkg;

    localparam logic [7:0]  AsciiZero = 8'h30;
    localparam logic [13:0] ValueMax  = 14'd9999;
    localparam logic [2:0]  MinDigLo  = 3'd1;
    localparam logic [2:0]  MinDigHi  = 3'd4;

    typedef struct packed {
        logic [13:0] value;
        logic [2:0]  min_digits;
    } t_in_item;

    typedef struct packed {
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [7:0] third_char;
        logic [7:0] fourth_char;
    } t_out_item;

    // Leading decimal digit of x for a place weight of unit (x < 10*unit).
    // Nine independent compares against the multiples of unit.
    function automatic logic [3:0] dec_digit(input logic [13:0] x,
                                             input logic [13:0] unit);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (x >= 14'(k) * unit) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [7:0] to_ascii(input logic [3:0] d);
        return AsciiZero + {4'b0000, d};
    endfunction

endpackage

`default_nettype wire

// ----- sv/four_digit_decimal_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// four_digit_decimal_ascii_formatter
// Unsigned value to left-aligned four-byte decimal ASCII text.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled (o_in_stall low)
// and returns one result item per item. The five register stages are:
// clamp, thousands digit, hundreds digit, tens and units
// digits, then text assembly into the output register. Each digit stage finds
// its digit with nine parallel compares against the multiples of the place
// weight and subtracts one multiple. Values above 9999 read as 9999, a
// minimum digit count of 0 reads as 1 and one above 4 reads as 4. The text
// carries max(natural digit count, minimum count) digits, most significant
// first; the bytes after the last digit are zero. A stall on the output
// freezes every stage at once, so o_in_stall is high exactly while a result
// waits and i_out_stall is high; nothing is dropped or repeated.
`default_nettype none

`include "four_digit_decimal_ascii_formatter_assert.svh"

module four_digit_decimal_ascii_formatter (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // input channel
    input  wire                       i_in_valid,
    input  wire fdaf_pkg::t_in_item   i_in_item,
    output logic                      o_in_stall,
    // output channel
    output logic                      o_out_valid,
    output fdaf_pkg::t_out_item       o_out_item,
    input  wire                       i_out_stall
);

    // whole pipe advances unless a finished result is held
    logic w_adv;

    // stage 1: clamped operands
    logic        r_s1_vld;
    logic [13:0] r_s1_val;
    logic [2:0]  r_s1_md;
    logic [13:0] n_s1_val;
    logic [2:0]  n_s1_md;

    // stage 2: thousands digit, remainder below 1000
    logic        r_s2_vld;
    logic [3:0]  r_s2_d3;
    logic [9:0]  r_s2_rem;
    logic [2:0]  r_s2_md;
    logic [3:0]  n_s2_d3;
    logic [13:0] n_s2_rem;

    // stage 3: hundreds digit, remainder below 100
    logic        r_s3_vld;
    logic [3:0]  r_s3_d3;
    logic [3:0]  r_s3_d2;
    logic [6:0]  r_s3_rem;
    logic [2:0]  r_s3_md;
    logic [3:0]  n_s3_d2;
    logic [13:0] n_s3_rem;

    // stage 4: all four digits
    logic        r_s4_vld;
    logic [3:0]  r_s4_d3;
    logic [3:0]  r_s4_d2;
    logic [3:0]  r_s4_d1;
    logic [3:0]  r_s4_d0;
    logic [2:0]  r_s4_md;
    logic [3:0]  n_s4_d1;
    logic [13:0] n_s4_d0;

    // stage 5: output register
    logic                r_out_vld;
    fdaf_pkg::t_out_item r_out_item;
    fdaf_pkg::t_out_item n_out_item;
    logic [2:0]          w_natural;
    logic [2:0]          w_ndig;

    // assertion helpers
    logic w_first_digit;
    logic w_tail_zero;
    logic w_short_text;

    assign w_adv      = !(r_out_vld && i_out_stall);
    assign o_in_stall = !w_adv;

    // ---- stage 1 logic: saturate value, clamp minimum count
    always_comb begin
        n_s1_val = (i_in_item.value > fdaf_pkg::ValueMax) ? fdaf_pkg::ValueMax
                                                         : i_in_item.value;
        if (i_in_item.min_digits < fdaf_pkg::MinDigLo) begin
            n_s1_md = fdaf_pkg::MinDigLo;
        end else if (i_in_item.min_digits > fdaf_pkg::MinDigHi) begin
            n_s1_md = fdaf_pkg::MinDigHi;
        end else begin
            n_s1_md = i_in_item.min_digits;
        end
    end

    // ---- stage 2 logic: thousands
    always_comb begin
        n_s2_d3  = fdaf_pkg::dec_digit(r_s1_val, 14'd1000);
        n_s2_rem = r_s1_val - 14'(n_s2_d3) * 14'd1000;
    end

    // ---- stage 3 logic: hundreds
    always_comb begin
        n_s3_d2  = fdaf_pkg::dec_digit(14'(r_s2_rem), 14'd100);
        n_s3_rem = 14'(r_s2_rem) - 14'(n_s3_d2) * 14'd100;
    end

    // ---- stage 4 logic: tens and units
    always_comb begin
        n_s4_d1 = fdaf_pkg::dec_digit(14'(r_s3_rem), 14'd10);
        n_s4_d0 = 14'(r_s3_rem) - 14'(n_s4_d1) * 14'd10;
    end

    // ---- stage 5 logic: digit count and left-aligned text
    always_comb begin
        priority if (r_s4_d3 != 4'd0) begin
            w_natural = 3'd4;
        end else if (r_s4_d2 != 4'd0) begin
            w_natural = 3'd3;
        end else if (r_s4_d1 != 4'd0) begin
            w_natural = 3'd2;
        end else begin
            w_natural = 3'd1;
        end
        w_ndig = (w_natural > r_s4_md) ? w_natural : r_s4_md;

        n_out_item = '0;
        unique case (w_ndig)
            3'd4: begin
                n_out_item.first_char  = fdaf_pkg::to_ascii(r_s4_d3);
                n_out_item.second_char = fdaf_pkg::to_ascii(r_s4_d2);
                n_out_item.third_char  = fdaf_pkg::to_ascii(r_s4_d1);
                n_out_item.fourth_char = fdaf_pkg::to_ascii(r_s4_d0);
            end
            3'd3: begin
                n_out_item.first_char  = fdaf_pkg::to_ascii(r_s4_d2);
                n_out_item.second_char = fdaf_pkg::to_ascii(r_s4_d1);
                n_out_item.third_char  = fdaf_pkg::to_ascii(r_s4_d0);
            end
            3'd2: begin
                n_out_item.first_char  = fdaf_pkg::to_ascii(r_s4_d1);
                n_out_item.second_char = fdaf_pkg::to_ascii(r_s4_d0);
            end
            default: begin
                // single digit (count is never outside one to four)
                n_out_item.first_char  = fdaf_pkg::to_ascii(r_s4_d0);
            end
        endcase
    end

    // ---- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= i_in_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    // ---- payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_val   <= n_s1_val;
            r_s1_md    <= n_s1_md;

            r_s2_d3    <= n_s2_d3;
            r_s2_rem   <= n_s2_rem[9:0];
            r_s2_md    <= r_s1_md;

            r_s3_d3    <= r_s2_d3;
            r_s3_d2    <= n_s3_d2;
            r_s3_rem   <= n_s3_rem[6:0];
            r_s3_md    <= r_s2_md;

            r_s4_d3    <= r_s3_d3;
            r_s4_d2    <= r_s3_d2;
            r_s4_d1    <= n_s4_d1;
            r_s4_d0    <= n_s4_d0[3:0];
            r_s4_md    <= r_s3_md;

            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // ---- assertions
    assign w_first_digit = (o_out_item.first_char >= fdaf_pkg::AsciiZero)
                        && (o_out_item.first_char <= 8'h39);
    assign w_short_text  = (o_out_item.second_char == 8'h00);
    assign w_tail_zero   = (o_out_item.third_char == 8'h00)
                        && (o_out_item.fourth_char == 8'h00);

    // the pipe only holds back input while a result sits blocked at the output
    `FDAF_ASSERT(a_stall_only_when_blocked, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall))
    // a result always starts with a decimal digit
    `FDAF_ASSERT(a_first_is_digit, i_clk, i_rst_n, o_out_valid |-> w_first_digit)
    // once the text ends, the remaining bytes are zero
    `FDAF_ASSERT(a_zero_tail, i_clk, i_rst_n, (o_out_valid && w_short_text) |-> w_tail_zero)
    // reset empties the pipe
    `FDAF_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

`default_nettype wire
